// ===== rtl/tccw_pkg.sv =====
// shared constants, field widths, opcodes and control/status structs for the
// text console char writer; no dependencies
package tccw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // item field widths
  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int COLUMN_W = 7;
  localparam int LINE_W   = 5;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE       = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE         = 8'd32;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic exec;         // item accepted, act on it this cycle
    logic load_result;  // move finished item into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_req;    // accepted item needs a whole-screen sweep
    logic sweep_done;   // last sweep write happens this cycle
  } ctl_stat_t;

endpackage

// ===== rtl/tccw_in_if.sv =====
// input item channel of the text console char writer
// depends on tccw_pkg for field widths
interface tccw_in_if;
  import tccw_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAR_W-1:0]   character;
  logic [ATTR_W-1:0]   attribute;
  logic                use_cursor;
  logic [COLUMN_W-1:0] column;
  logic [LINE_W-1:0]   line;

  modport source (
    output valid, opcode, character, attribute, use_cursor, column, line,
    input  ready
  );

  modport sink (
    input  valid, opcode, character, attribute, use_cursor, column, line,
    output ready
  );

endinterface

// ===== rtl/tccw_out_if.sv =====
// result item channel of the text console char writer
// depends on tccw_pkg for field widths
interface tccw_out_if;
  import tccw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CURSOR_W-1:0] cursor_cell;
  logic                scrolled;
  logic [CHAR_W-1:0]   cell_character;
  logic [ATTR_W-1:0]   cell_attribute;

  modport source (
    output valid, cursor_cell, scrolled, cell_character, cell_attribute,
    input  ready
  );

  modport sink (
    input  valid, cursor_cell, scrolled, cell_character, cell_attribute,
    output ready
  );

endinterface

// ===== rtl/tccw_ctrl.sv =====
// controller state machine of the text console char writer
// depends on tccw_pkg for the command and status structs
module tccw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tccw_pkg::ctl_cmd_t  cmd,
  input  tccw_pkg::ctl_stat_t stat
);
  import tccw_pkg::*;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t state;

  assign in_ready        = (state == ST_IDLE);
  assign cmd.exec        = in_ready && in_valid;
  assign cmd.load_result = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end
      case (state)
        ST_INIT: begin
          if (stat.sweep_done) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd.exec) begin
            state <= stat.sweep_req ? ST_SWEEP : ST_DONE;
          end
        end
        ST_SWEEP: begin
          if (stat.sweep_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd.load_result) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tccw_datapath.sv =====
// datapath of the text console char writer: screen memory, cursor,
// sweep engine for scroll and fill, result register; depends on tccw_pkg
module tccw_datapath #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tccw_pkg::ctl_cmd_t              cmd,
  output tccw_pkg::ctl_stat_t             stat,
  input  logic                            cfg_write,
  input  logic [tccw_pkg::ATTR_W-1:0]     cfg_data,
  input  logic [tccw_pkg::OPCODE_W-1:0]   opcode,
  input  logic [tccw_pkg::CHAR_W-1:0]     character,
  input  logic [tccw_pkg::ATTR_W-1:0]     attribute,
  input  logic                            use_cursor,
  input  logic [tccw_pkg::COLUMN_W-1:0]   column,
  input  logic [tccw_pkg::LINE_W-1:0]     line,
  output logic [tccw_pkg::CURSOR_W-1:0]   cursor_cell,
  output logic                            scrolled,
  output logic [tccw_pkg::CHAR_W-1:0]     cell_character,
  output logic [tccw_pkg::ATTR_W-1:0]     cell_attribute
);
  import tccw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

  // screen memory, character in the low byte
  logic [CELL_W-1:0] cells [CELLS];
  logic [CELL_W-1:0] rdata;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  // cursor and config
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ATTR_W-1:0] default_attr;

  // sweep engine
  logic              sweep_active;
  logic              sweep_copy;
  logic [ADDR_W-1:0] sweep_idx;
  logic [CELL_W-1:0] fill_value;
  logic              stage_valid;
  logic              stage_from_mem;
  logic [ADDR_W-1:0] stage_addr;

  // item bookkeeping
  logic item_scrolled;
  logic item_read;

  // decode of the item at the input
  opcode_t           op;
  logic [COL_W-1:0]  sat_col;
  logic [ROW_W-1:0]  sat_row;
  logic [COL_W-1:0]  tcol;
  logic [ROW_W-1:0]  trow;
  logic [COL_W-1:0]  put_col;
  logic              is_newline;
  logic              wrap;
  logic              scroll_put;
  logic [ADDR_W-1:0] cell_addr;
  logic [ATTR_W-1:0] attr_eff;
  logic [ADDR_W-1:0] cur_idx;
  logic              copy_phase;

  always_comb begin
    op         = opcode_t'(opcode);
    sat_col    = (int'(column) >= COLUMNS) ? LAST_COL : COL_W'(column);
    sat_row    = (int'(line) >= ROWS) ? LAST_ROW : ROW_W'(line);
    tcol       = (op == OP_PUT && use_cursor) ? cur_col : sat_col;
    trow       = (op == OP_PUT && use_cursor) ? cur_row : sat_row;
    is_newline = (character == NEWLINE_CODE);
    put_col    = is_newline ? LAST_COL : tcol;
    wrap       = (put_col == LAST_COL);
    scroll_put = (op == OP_PUT) && wrap && (trow == LAST_ROW);
    cell_addr  = ADDR_W'(trow) * ROW_STRIDE + ADDR_W'(tcol);
    attr_eff   = (attribute == '0) ? default_attr : attribute;
    cur_idx    = ADDR_W'(cur_row) * ROW_STRIDE + ADDR_W'(cur_col);
    copy_phase = sweep_copy && (sweep_idx < COPY_END);
  end

  assign stat.sweep_req  = scroll_put || (op == OP_CLEAR);
  assign stat.sweep_done = stage_valid && (stage_addr == LAST_CELL);

  // memory ports: sweep and item access never overlap
  always_comb begin
    mem_we    = stage_valid || (cmd.exec && op == OP_PUT && !is_newline);
    mem_waddr = stage_valid ? stage_addr : cell_addr;
    if (stage_valid) begin
      mem_wdata = stage_from_mem ? rdata : fill_value;
    end else begin
      mem_wdata = {attr_eff, character};
    end
    mem_re    = (cmd.exec && op == OP_READ) || (sweep_active && copy_phase);
    mem_raddr = sweep_active ? sweep_idx + ROW_STRIDE : cell_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= cells[mem_raddr];
    end
  end

  // cursor, config and sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col        <= '0;
      cur_row        <= '0;
      default_attr   <= DEFAULT_ATTR_RESET;
      sweep_active   <= 1'b1;
      sweep_copy     <= 1'b0;
      sweep_idx      <= '0;
      fill_value     <= '0;
      stage_valid    <= 1'b0;
      stage_from_mem <= 1'b0;
      stage_addr     <= '0;
    end else begin
      if (cfg_write) begin
        default_attr <= cfg_data;
      end
      if (sweep_active) begin
        sweep_idx <= sweep_idx + 1'b1;
        if (sweep_idx == LAST_CELL) begin
          sweep_active <= 1'b0;
        end
      end
      stage_valid    <= sweep_active;
      stage_addr     <= sweep_idx;
      stage_from_mem <= copy_phase;
      if (cmd.exec) begin
        case (op)
          OP_PUT: begin
            if (wrap) begin
              cur_col <= '0;
              cur_row <= (trow == LAST_ROW) ? trow : trow + 1'b1;
            end else begin
              cur_col <= put_col + 1'b1;
              cur_row <= trow;
            end
            if (scroll_put) begin
              sweep_active <= 1'b1;
              sweep_copy   <= 1'b1;
              sweep_idx    <= '0;
              fill_value   <= '0;
            end
          end
          OP_CLEAR: begin
            cur_col      <= '0;
            cur_row      <= '0;
            sweep_active <= 1'b1;
            sweep_copy   <= 1'b0;
            sweep_idx    <= '0;
            fill_value   <= {default_attr, SPACE_CODE};
          end
          default: begin
          end
        endcase
      end
    end
  end

  // item flags and result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      item_scrolled <= scroll_put;
      item_read     <= (op == OP_READ);
    end
    if (cmd.load_result) begin
      cursor_cell    <= CURSOR_W'(cur_idx);
      scrolled       <= item_scrolled;
      cell_character <= item_read ? rdata[CHAR_W-1:0] : '0;
      cell_attribute <= item_read ? rdata[CELL_W-1:CHAR_W] : '0;
    end
  end

endmodule

// ===== rtl/text_console_char_writer_top.sv =====
// top level of the text console char writer: controller plus datapath
// depends on tccw_pkg, tccw_in_if, tccw_out_if, tccw_ctrl, tccw_datapath
//
// text-mode console engine holding COLUMNS x ROWS cells of character and
// attribute plus a cursor. one result item comes back for every input item.
// for put, read and no-op items the accept cycle does the memory write or
// read, and the done state then loads the output register once it is free.
// a put that runs off the end of the screen scrolls, and a clear fills the
// screen; both walk the single-port-pair screen memory one cell a cycle.
// after reset the memory is swept to zero before the first item is taken;
// the config write is taken at any time. the output register lets the next
// item in while the last result still waits to be taken.
module text_console_char_writer_top #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  tccw_in_if.sink                     req,
  tccw_out_if.source                  rsp,
  input  logic                        cfg_write,
  input  logic [tccw_pkg::ATTR_W-1:0] cfg_data
);
  import tccw_pkg::*;

  // command and status between controller and datapath
  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // controller owns the handshakes
  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath owns memory, cursor and the result payload
  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .opcode         (req.opcode),
    .character      (req.character),
    .attribute      (req.attribute),
    .use_cursor     (req.use_cursor),
    .column         (req.column),
    .line           (req.line),
    .cursor_cell    (rsp.cursor_cell),
    .scrolled       (rsp.scrolled),
    .cell_character (rsp.cell_character),
    .cell_attribute (rsp.cell_attribute)
  );

endmodule
